>>> sv/npmd_pkg.sv
`timescale 1ns / 1ps

package npmd_pkg;

    localparam int NCH        = 4;   // channel ports on the top level
    localparam int SAMPLE_W   = 16;  // width of one channel port
    localparam int QB         = 16;  // quotient bits per output channel
    localparam int WT_W       = 16;  // filter weight width
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int TAP_W      = 3;
    localparam int DIVCNT_W   = 5;

    // MAC tap order for one channel: three horizontal taps, then three vertical taps
    localparam logic [TAP_W-1:0] TAP_PREV1  = 3'd0;
    localparam logic [TAP_W-1:0] TAP_PREV0  = 3'd1;
    localparam logic [TAP_W-1:0] TAP_CUR    = 3'd2;
    localparam logic [TAP_W-1:0] TAP_FIRST  = 3'd3;
    localparam logic [TAP_W-1:0] TAP_SECOND = 3'd4;
    localparam logic [TAP_W-1:0] TAP_HSUM   = 3'd5;

    typedef struct packed {
        logic             load;
        logic             mac_en;
        logic [TAP_W-1:0] tap;
        logic             wr_first;
        logic             wr_second;
        logic             div_init;
        logic             div_step;
        logic             out_load;
        logic             last;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

>>> sv/npmd_ctrl.sv
`timescale 1ns / 1ps

module npmd_ctrl #(
    parameter int MAX_WIDTH    = 4096,
    parameter int MAX_CHANNELS = 4,
    parameter int COL_W        = 12,
    parameter int CH_W         = 2,
    parameter int DX_W         = 13
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              in_valid,
    output logic                                              in_stall,
    input  logic                                              cfg_valid,
    output logic                                              cfg_ready,
    input  logic [npmd_pkg::CFG_IDX_W-1:0]                    cfg_index,
    input  logic [npmd_pkg::CFG_DATA_W-1:0]                   cfg_data,
    input  npmd_pkg::dp_status_t                              status,
    output npmd_pkg::dp_cmd_t                                 cmd,
    output logic [CH_W-1:0]                                   chan,
    output logic [CH_W-1:0]                                   c_last,
    output logic [COL_W-1:0]                                  xo,
    output logic                                              wide,
    output logic [2:0][npmd_pkg::WT_W-1:0]                    wh,
    output logic [2:0][npmd_pkg::WT_W-1:0]                    wv,
    output logic [DX_W-1:0]                                   dx,
    output logic [15:0]                                       dy
);
    import npmd_pkg::*;

    localparam int EW_W = $clog2(MAX_WIDTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDE     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 8'd3;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MAC  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [TAP_W-1:0]     tap_reg, tap_next;
    logic [CH_W-1:0]      chan_reg, chan_next;
    logic [DIVCNT_W-1:0]  cnt_reg, cnt_next;
    logic [12:0]          src_width_reg;
    logic [15:0]          src_height_reg;
    logic                 wide_reg;
    logic [2:0]           chan_count_reg;
    logic [COL_W-1:0]     col_reg;
    logic [15:0]          row_reg;
    logic                 emit_reg, wr_first_reg, wr_second_reg, last_reg;
    logic [COL_W-1:0]     xo_reg;
    logic [2:0][WT_W-1:0] wh_reg, wv_reg;
    logic [DX_W-1:0]      dx_reg;
    logic [15:0]          dy_reg;

    logic [EW_W-1:0]      eff_w;
    logic [15:0]          eff_h;
    logic [2:0]           eff_c;
    logic [COL_W-1:0]     col, hw, xo_c;
    logic [15:0]          row, hh, yo_c;
    logic                 have_h, emit_c, wr_first_c, wr_second_c, last_c;
    logic [2:0][WT_W-1:0] wh_c, wv_c;
    logic [DX_W-1:0]      dx_c;
    logic [15:0]          dy_c;
    logic                 accept, cfg_hit;

    always_comb
    begin
        if (src_width_reg == 13'd0)
            eff_w = EW_W'(1);
        else if (32'(src_width_reg) > MAX_WIDTH)
            eff_w = EW_W'(MAX_WIDTH);
        else
            eff_w = EW_W'(src_width_reg);
        eff_h = (src_height_reg == 16'd0) ? 16'd1 : src_height_reg;
        if (chan_count_reg == 3'd0)
            eff_c = 3'd1;
        else if (32'(chan_count_reg) > MAX_CHANNELS)
            eff_c = 3'(MAX_CHANNELS);
        else
            eff_c = chan_count_reg;
    end

    // Filter setup from the position of the incoming pixel
    always_comb
    begin
        col = (32'(col_reg) >= 32'(eff_w)) ? '0 : col_reg;
        row = (row_reg >= eff_h) ? 16'd0 : row_reg;
        hw  = COL_W'(eff_w >> 1);
        hh  = eff_h >> 1;
        if (eff_w[0])
        begin
            have_h  = (hw != '0) && (col >= COL_W'(2)) && !col[0];
            xo_c    = (col >> 1) - COL_W'(1);
            wh_c[0] = WT_W'(hw - xo_c);
            wh_c[1] = WT_W'(hw);
            wh_c[2] = WT_W'(xo_c) + WT_W'(1);
            dx_c    = DX_W'(32'(hw) * 2 + 1);
        end
        else
        begin
            have_h  = (hw != '0) && col[0];
            xo_c    = col >> 1;
            wh_c[0] = WT_W'(0);
            wh_c[1] = WT_W'(1);
            wh_c[2] = WT_W'(1);
            dx_c    = DX_W'(2);
        end
        emit_c      = 1'b0;
        wr_first_c  = 1'b0;
        wr_second_c = 1'b0;
        yo_c        = row >> 1;
        wv_c[0]     = WT_W'(1);
        wv_c[1]     = WT_W'(0);
        wv_c[2]     = WT_W'(1);
        dy_c        = 16'd2;
        if (hh != 16'd0)
        begin
            if (eff_h[0])
            begin
                if (!row[0])
                begin
                    wr_first_c = 1'b1;
                    if (row >= 16'd2)
                    begin
                        emit_c  = 1'b1;
                        yo_c    = (row >> 1) - 16'd1;
                        wv_c[0] = hh - yo_c;
                        wv_c[1] = hh;
                        wv_c[2] = yo_c + 16'd1;
                        dy_c    = {hh[14:0], 1'b1};
                    end
                end
                else
                    wr_second_c = 1'b1;
            end
            else if (!row[0])
                wr_first_c = 1'b1;
            else
                emit_c = 1'b1;
        end
        last_c = (xo_c == hw - COL_W'(1)) && (yo_c == hh - 16'd1);
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && cfg_ready;

    always_comb
    begin
        state_next = state_reg;
        tap_next   = tap_reg;
        chan_next  = chan_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.tap    = tap_reg;
        cmd.last   = last_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = accept;
                if (accept && have_h)
                begin
                    state_next = S_MAC;
                    tap_next   = TAP_PREV1;
                    chan_next  = '0;
                end
            end
            S_MAC:
            begin
                cmd.mac_en    = 1'b1;
                cmd.wr_first  = (tap_reg == TAP_FIRST) && wr_first_reg;
                cmd.wr_second = (tap_reg == TAP_FIRST) && wr_second_reg;
                if (tap_reg == TAP_HSUM)
                begin
                    tap_next = TAP_PREV1;
                    if (chan_reg == c_last)
                    begin
                        state_next = emit_reg ? S_DIV : S_IDLE;
                        cnt_next   = '0;
                    end
                    else
                        chan_next = chan_reg + CH_W'(1);
                end
                else
                    tap_next = tap_reg + TAP_W'(1);
            end
            S_DIV:
            begin
                cmd.div_init = (cnt_reg == '0);
                cmd.div_step = (cnt_reg != '0);
                cnt_next     = cnt_reg + DIVCNT_W'(1);
                if (cnt_reg == DIVCNT_W'(QB))
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tap_reg        <= TAP_PREV1;
            chan_reg       <= '0;
            cnt_reg        <= '0;
            src_width_reg  <= 13'd1;
            src_height_reg <= 16'd1;
            wide_reg       <= 1'b0;
            chan_count_reg <= 3'd4;
            col_reg        <= '0;
            row_reg        <= 16'd0;
            emit_reg       <= 1'b0;
            wr_first_reg   <= 1'b0;
            wr_second_reg  <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
            chan_reg  <= chan_next;
            cnt_reg   <= cnt_next;
            if (cfg_hit)
            begin
                case (cfg_index)
                    REG_WIDTH:    src_width_reg  <= cfg_data[12:0];
                    REG_HEIGHT:   src_height_reg <= cfg_data;
                    REG_WIDE:     wide_reg       <= cfg_data[0];
                    REG_CHANNELS: chan_count_reg <= cfg_data[2:0];
                    default:      ;
                endcase
                // any known register starts a new image
                if (cfg_index <= REG_CHANNELS)
                begin
                    col_reg <= '0;
                    row_reg <= 16'd0;
                end
            end
            else if (accept)
            begin
                emit_reg      <= emit_c;
                wr_first_reg  <= wr_first_c;
                wr_second_reg <= wr_second_c;
                last_reg      <= last_c;
                if (32'(col) + 1 >= 32'(eff_w))
                begin
                    col_reg <= '0;
                    row_reg <= (32'(row) + 1 >= 32'(eff_h)) ? 16'd0 : row + 16'd1;
                end
                else
                begin
                    col_reg <= col + COL_W'(1);
                    row_reg <= row;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            xo_reg <= xo_c;
            wh_reg <= wh_c;
            wv_reg <= wv_c;
            dx_reg <= dx_c;
            dy_reg <= dy_c;
        end
    end

    assign chan   = chan_reg;
    assign c_last = CH_W'(eff_c - 3'd1);
    assign xo     = xo_reg;
    assign wide   = wide_reg;
    assign wh     = wh_reg;
    assign wv     = wv_reg;
    assign dx     = dx_reg;
    assign dy     = dy_reg;

endmodule

>>> sv/npmd_dpath.sv
`timescale 1ns / 1ps

module npmd_dpath #(
    parameter int MAX_CHANNELS = 4,
    parameter int SAMPLE_BITS  = 16,
    parameter int CH_W         = 2,
    parameter int COL_W        = 12,
    parameter int DX_W         = 13,
    parameter int HS_W         = 29,
    parameter int TOT_W        = 45,
    parameter int DEN_W        = 29,
    parameter int SLOTS        = 8192,
    parameter int ADDR_W       = 13
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  npmd_pkg::dp_cmd_t                                 cmd,
    output npmd_pkg::dp_status_t                              status,
    input  logic [CH_W-1:0]                                   chan,
    input  logic [CH_W-1:0]                                   c_last,
    input  logic [COL_W-1:0]                                  xo,
    input  logic                                              wide,
    input  logic [2:0][npmd_pkg::WT_W-1:0]                    wh,
    input  logic [2:0][npmd_pkg::WT_W-1:0]                    wv,
    input  logic [DX_W-1:0]                                   dx,
    input  logic [15:0]                                       dy,
    input  logic [npmd_pkg::NCH-1:0][npmd_pkg::SAMPLE_W-1:0]  in_data,
    output logic [npmd_pkg::NCH-1:0][npmd_pkg::SAMPLE_W-1:0]  out_data,
    output logic                                              out_last,
    output logic                                              out_valid,
    input  logic                                              out_stall
);
    import npmd_pkg::*;

    localparam int DIV_W = (DEN_W + QB - 1 > TOT_W) ? DEN_W + QB - 1 : TOT_W;

    logic [SAMPLE_BITS-1:0] cur_op   [MAX_CHANNELS];
    logic [SAMPLE_BITS-1:0] p0_op    [MAX_CHANNELS];
    logic [SAMPLE_BITS-1:0] p1_op    [MAX_CHANNELS];
    logic [SAMPLE_BITS-1:0] prev0_reg[MAX_CHANNELS];
    logic [SAMPLE_BITS-1:0] prev1_reg[MAX_CHANNELS];
    logic [SAMPLE_BITS-1:0] masked   [MAX_CHANNELS];
    logic [TOT_W-1:0]       tot_reg  [MAX_CHANNELS];
    logic [DIV_W-1:0]       rem_reg  [MAX_CHANNELS];
    logic [QB-1:0]          q_reg    [MAX_CHANNELS];
    logic [QB-1:0]          out_reg  [MAX_CHANNELS];
    logic [DIV_W:0]         trial    [MAX_CHANNELS];

    logic [HS_W-1:0]  mem_first [SLOTS];
    logic [HS_W-1:0]  mem_second[SLOTS];
    logic [HS_W-1:0]  rd_first, rd_second, hs_reg;
    logic [ADDR_W-1:0] addr;

    logic [TOT_W-1:0] acc_reg, acc_next, prod;
    logic [HS_W-1:0]  opnd;
    logic [WT_W-1:0]  wsel;
    logic [DEN_W-1:0] den_reg;
    logic [DIV_W-1:0] dsh_reg;
    logic             out_valid_reg, out_last_reg;

    always_comb
    begin
        for (int i = 0; i < MAX_CHANNELS; i++)
            masked[i] = SAMPLE_BITS'(in_data[i]) &
                        (wide ? {SAMPLE_BITS{1'b1}} : SAMPLE_BITS'(8'hFF));
    end

    always_comb
    begin
        case (cmd.tap)
            TAP_PREV1:  begin opnd = HS_W'(p1_op[chan]);  wsel = wh[0]; end
            TAP_PREV0:  begin opnd = HS_W'(p0_op[chan]);  wsel = wh[1]; end
            TAP_CUR:    begin opnd = HS_W'(cur_op[chan]); wsel = wh[2]; end
            TAP_FIRST:  begin opnd = rd_first;            wsel = wv[0]; end
            TAP_SECOND: begin opnd = rd_second;           wsel = wv[1]; end
            TAP_HSUM:   begin opnd = hs_reg;              wsel = wv[2]; end
            default:    begin opnd = '0;                  wsel = '0;    end
        endcase
        // a zero weight drops the tap, whatever its operand holds
        prod     = (wsel == '0) ? '0 : TOT_W'(wsel) * TOT_W'(opnd);
        // the first tap of each sum restarts the accumulator
        acc_next = (cmd.tap == TAP_PREV1 || cmd.tap == TAP_FIRST) ? prod : acc_reg + prod;
    end

    assign addr = ADDR_W'(32'(xo) * MAX_CHANNELS + 32'(chan));

    always_ff @(posedge clk)
    begin
        if (cmd.wr_first)
            mem_first[addr] <= HS_W'(acc_reg);
        rd_first <= mem_first[addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_second)
            mem_second[addr] <= HS_W'(acc_reg);
        rd_second <= mem_second[addr];
    end

    always_comb
    begin
        for (int i = 0; i < MAX_CHANNELS; i++)
            trial[i] = {1'b0, rem_reg[i]} - {1'b0, dsh_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                cur_op[i]  <= masked[i];
                p0_op[i]   <= prev0_reg[i];
                p1_op[i]   <= prev1_reg[i];
                tot_reg[i] <= '0;
                if (i <= int'(c_last))
                begin
                    prev1_reg[i] <= prev0_reg[i];
                    prev0_reg[i] <= masked[i];
                end
            end
        end
        if (cmd.mac_en)
        begin
            acc_reg <= acc_next;
            den_reg <= DEN_W'(dx) * DEN_W'(dy);
            if (cmd.tap == TAP_FIRST)
                hs_reg <= HS_W'(acc_reg);
            if (cmd.tap == TAP_HSUM)
                tot_reg[chan] <= acc_next;
        end
        if (cmd.div_init)
        begin
            dsh_reg <= DIV_W'(den_reg) << (QB - 1);
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                rem_reg[i] <= DIV_W'(tot_reg[i]);
                q_reg[i]   <= '0;
            end
        end
        else if (cmd.div_step)
        begin
            dsh_reg <= dsh_reg >> 1;
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                if (!trial[i][DIV_W])
                    rem_reg[i] <= trial[i][DIV_W-1:0];
                q_reg[i] <= {q_reg[i][QB-2:0], !trial[i][DIV_W]};
            end
        end
        if (cmd.out_load)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
                out_reg[i] <= q_reg[i];
            out_last_reg <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign out_last        = out_last_reg;

    genvar g;
    generate
        for (g = 0; g < NCH; g++)
        begin : g_out
            if (g < MAX_CHANNELS)
            begin : g_used
                assign out_data[g] = SAMPLE_W'(out_reg[g]);
            end
            else
            begin : g_unused
                assign out_data[g] = '0;
            end
        end
    endgenerate

endmodule

>>> sv/npot_mipmap_downsample.sv
`timescale 1ns / 1ps
// A pixel that completes no horizontal pair or triple is taken without stalling the input.
// Other pixels stall the input while six MAC taps run per channel in use (one shared 16 x 29
// multiplier), then, when the pixel finishes an output pixel, the restoring divider and the
// output stage, which waits while out_stall holds; no new pixel is taken before that is done.
// Reset: rst_n is asynchronous, active low; registers return to 1x1, 8 bit, 4 channels.
module npot_mipmap_downsample #(
    parameter int MAX_WIDTH    = 4096,
    parameter int MAX_CHANNELS = 4,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [npmd_pkg::SAMPLE_W-1:0]         in_ch0,
    input  logic [npmd_pkg::SAMPLE_W-1:0]         in_ch1,
    input  logic [npmd_pkg::SAMPLE_W-1:0]         in_ch2,
    input  logic [npmd_pkg::SAMPLE_W-1:0]         in_ch3,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [npmd_pkg::SAMPLE_W-1:0]         out_ch0,
    output logic [npmd_pkg::SAMPLE_W-1:0]         out_ch1,
    output logic [npmd_pkg::SAMPLE_W-1:0]         out_ch2,
    output logic [npmd_pkg::SAMPLE_W-1:0]         out_ch3,
    output logic                                  out_last,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [npmd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [npmd_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import npmd_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int DX_W   = $clog2(MAX_WIDTH + 2);
    localparam int HS_W   = SAMPLE_BITS + DX_W;
    localparam int TOT_W  = HS_W + 16;
    localparam int DEN_W  = DX_W + 16;
    localparam int SLOTS  = (MAX_WIDTH / 2) * MAX_CHANNELS;
    localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    dp_cmd_t                   cmd;
    dp_status_t                status;
    logic [CH_W-1:0]           chan, c_last;
    logic [COL_W-1:0]          xo;
    logic                      wide;
    logic [2:0][WT_W-1:0]      wh, wv;
    logic [DX_W-1:0]           dx;
    logic [15:0]               dy;
    logic [NCH-1:0][SAMPLE_W-1:0] in_data, out_data;

    assign in_data = {in_ch3, in_ch2, in_ch1, in_ch0};
    assign out_ch0 = out_data[0];
    assign out_ch1 = out_data[1];
    assign out_ch2 = out_data[2];
    assign out_ch3 = out_data[3];

    npmd_ctrl #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_CHANNELS(MAX_CHANNELS),
        .COL_W(COL_W), .CH_W(CH_W), .DX_W(DX_W)
    ) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .status(status), .cmd(cmd), .chan(chan),
        .c_last(c_last), .xo(xo), .wide(wide), .wh(wh), .wv(wv), .dx(dx), .dy(dy)
    );

    npmd_dpath #(
        .MAX_CHANNELS(MAX_CHANNELS), .SAMPLE_BITS(SAMPLE_BITS), .CH_W(CH_W),
        .COL_W(COL_W), .DX_W(DX_W), .HS_W(HS_W), .TOT_W(TOT_W), .DEN_W(DEN_W),
        .SLOTS(SLOTS), .ADDR_W(ADDR_W)
    ) u_dpath (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status), .chan(chan),
        .c_last(c_last), .xo(xo), .wide(wide), .wh(wh), .wv(wv), .dx(dx), .dy(dy),
        .in_data(in_data), .out_data(out_data), .out_last(out_last),
        .out_valid(out_valid), .out_stall(out_stall)
    );

endmodule

>>> sv/npmd_checker.sv
`timescale 1ns / 1ps

module npmd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] out_ch0,
    input logic [15:0] out_ch1,
    input logic [15:0] out_ch2,
    input logic [15:0] out_ch3,
    input logic        out_last
);

    // hold a stalled transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_ch0) && $stable(out_ch1)
            && $stable(out_ch2) && $stable(out_ch3) && $stable(out_last))
        else $error("stalled output changed");

    // a result appears only as the input side leaves its busy phase
    a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall) && !in_stall)
        else $error("result raised without preceding computation");

    // nothing is pending right after reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid && !in_stall)
        else $error("block not empty after reset");

endmodule

bind npot_mipmap_downsample npmd_checker u_npmd_checker (.*);

>>> dv/npot_mipmap_downsample_tb.sv
`timescale 1ns / 1ps

module npot_mipmap_downsample_tb;

    import npmd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDE_SAMPLES  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED        = 8'd4;

    localparam int LINE_SLOTS = 8192;

    typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS, FILL_ALTERNATE} fill_t;

    typedef struct packed {
        logic [3:0][15:0] ch;
        logic             last;
    } level_pixel_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [15:0] in_ch0, in_ch1, in_ch2, in_ch3;
    logic out_valid;
    logic out_stall;
    logic [15:0] out_ch0, out_ch1, out_ch2, out_ch3;
    logic out_last;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    npot_mipmap_downsample u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_ch0    (in_ch0),
        .in_ch1    (in_ch1),
        .in_ch2    (in_ch2),
        .in_ch3    (in_ch3),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_ch0   (out_ch0),
        .out_ch1   (out_ch1),
        .out_ch2   (out_ch2),
        .out_ch3   (out_ch3),
        .out_last  (out_last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the block's registers and filter state
    logic [12:0] geo_width;
    logic [15:0] geo_height;
    logic        geo_wide;
    logic [2:0]  geo_channels;
    int unsigned pos_col;
    int unsigned pos_row;
    longint unsigned prev_px [8];
    longint unsigned first_sums [LINE_SLOTS];
    longint unsigned second_sums [LINE_SLOTS];

    logic [3:0][15:0] pixel_queue [$];
    level_pixel_t     level_queue [$];

    int sender_idle_pct;
    int receiver_stall_pct;
    int mismatches;

    task automatic shadow_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        case (idx)
            REG_SRC_WIDTH:     geo_width = val[12:0];
            REG_SRC_HEIGHT:    geo_height = val;
            REG_WIDE_SAMPLES:  geo_wide = val[0];
            REG_CHANNEL_COUNT: geo_channels = val[2:0];
            default:           return;
        endcase
        pos_col = 0;
        pos_row = 0;
    endtask

    task automatic filter_pixel(input logic [3:0][15:0] px);
        int unsigned w_eff, h_eff, c_eff, col, row, hw, hh, xo, yo, base;
        longint unsigned dx, dy, den;
        longint unsigned cur [4];
        longint unsigned hsum [4];
        longint unsigned total [4];
        bit have_h, emit;
        level_pixel_t res;
        w_eff = (geo_width == 0) ? 1 : (geo_width > 4096) ? 4096 : geo_width;
        h_eff = (geo_height == 0) ? 1 : geo_height;
        c_eff = (geo_channels == 0) ? 1 : (geo_channels > 4) ? 4 : geo_channels;
        col = (pos_col >= w_eff) ? 0 : pos_col;
        row = (pos_row >= h_eff) ? 0 : pos_row;
        hw = w_eff / 2;
        hh = h_eff / 2;
        dx = 2;
        dy = 2;
        xo = 0;
        yo = 0;
        have_h = 0;
        emit = 0;
        for (int c = 0; c < 4; c++) begin
            cur[c] = geo_wide ? px[c] : px[c][7:0];
            hsum[c] = 0;
            total[c] = 0;
        end
        if (hw > 0) begin
            if (w_eff[0]) begin
                if (col >= 2 && !col[0]) begin
                    xo = col / 2 - 1;
                    dx = 2 * hw + 1;
                    for (int c = 0; c < c_eff; c++)
                        hsum[c] = (hw - xo) * prev_px[4 + c] + hw * prev_px[c]
                                + (xo + 1) * cur[c];
                    have_h = 1;
                end
            end else if (col[0]) begin
                xo = col / 2;
                for (int c = 0; c < c_eff; c++)
                    hsum[c] = prev_px[c] + cur[c];
                have_h = 1;
            end
        end
        if (have_h && hh > 0 && xo < 2048) begin
            base = xo * 4;
            if (h_eff[0]) begin
                if (!row[0]) begin
                    if (row >= 2) begin
                        yo = row / 2 - 1;
                        dy = 2 * hh + 1;
                        for (int c = 0; c < c_eff; c++)
                            total[c] = (hh - yo) * first_sums[base + c]
                                     + hh * second_sums[base + c] + (yo + 1) * hsum[c];
                        emit = 1;
                    end
                    for (int c = 0; c < c_eff; c++)
                        first_sums[base + c] = hsum[c];
                end else begin
                    for (int c = 0; c < c_eff; c++)
                        second_sums[base + c] = hsum[c];
                end
            end else if (!row[0]) begin
                for (int c = 0; c < c_eff; c++)
                    first_sums[base + c] = hsum[c];
            end else begin
                yo = row / 2;
                for (int c = 0; c < c_eff; c++)
                    total[c] = first_sums[base + c] + hsum[c];
                emit = 1;
            end
            if (emit) begin
                den = dx * dy;
                for (int c = 0; c < 4; c++)
                    res.ch[c] = (c < c_eff) ? 16'(total[c] / den) : 16'd0;
                res.last = (xo == hw - 1 && yo == hh - 1);
                level_queue.push_back(res);
            end
        end
        for (int c = 0; c < c_eff; c++) begin
            prev_px[4 + c] = prev_px[c];
            prev_px[c] = cur[c];
        end
        col++;
        if (col >= w_eff) begin
            col = 0;
            row++;
            if (row >= h_eff)
                row = 0;
        end
        pos_col = col;
        pos_row = row;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // source side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_ch0 <= '0;
            in_ch1 <= '0;
            in_ch2 <= '0;
            in_ch3 <= '0;
        end else begin
            if (in_valid && !in_stall)
                filter_pixel({in_ch3, in_ch2, in_ch1, in_ch0});
            if (!in_valid || !in_stall) begin
                if (pixel_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    logic [3:0][15:0] nxt;
                    nxt = pixel_queue.pop_front();
                    in_valid <= 1'b1;
                    in_ch0 <= nxt[0];
                    in_ch1 <= nxt[1];
                    in_ch2 <= nxt[2];
                    in_ch3 <= nxt[3];
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                level_pixel_t got, want;
                got.ch = {out_ch3, out_ch2, out_ch1, out_ch0};
                got.last = out_last;
                if (level_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output pixel: %h last %b", got.ch, got.last);
                end else begin
                    want = level_queue.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h last %b, got %h last %b",
                                     want.ch, want.last, got.ch, got.last);
                    end
                end
            end
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        shadow_write(idx, val);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(input int w, input int h, input bit wide, input int chans);
        reg_write(REG_SRC_WIDTH, 16'(w));
        reg_write(REG_SRC_HEIGHT, 16'(h));
        reg_write(REG_WIDE_SAMPLES, 16'(wide));
        reg_write(REG_CHANNEL_COUNT, 16'(chans));
    endtask

    task automatic queue_pixels(input int n, input fill_t fill);
        logic [3:0][15:0] px;
        for (int i = 0; i < n; i++) begin
            for (int c = 0; c < 4; c++)
                case (fill)
                    FILL_ONES:      px[c] = 16'hffff;
                    FILL_ZEROS:     px[c] = 16'h0000;
                    FILL_ALTERNATE: px[c] = ((i + c) % 2) ? 16'hffff : 16'h0000;
                    default:        px[c] = 16'($urandom);
                endcase
            pixel_queue.push_back(px);
        end
    endtask

    // wait out every pending transaction, then let the block settle
    task automatic drain();
        forever begin
            @(negedge clk);
            if (pixel_queue.size() == 0 && !in_valid && level_queue.size() == 0)
                break;
        end
        repeat (60) @(negedge clk);
    endtask

    task automatic pick_idling(input int phase);
        case (phase % 4)
            0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
            1: begin sender_idle_pct = 71; receiver_stall_pct = 0; end
            2: begin sender_idle_pct = 0; receiver_stall_pct = 71; end
            default: begin sender_idle_pct = 10; receiver_stall_pct = 10; end
        endcase
    endtask

    initial
    begin
        int w, h, n;
        mismatches = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        geo_width = 13'd1;
        geo_height = 16'd1;
        geo_wide = 1'b0;
        geo_channels = 3'd4;
        pos_col = 0;
        pos_row = 0;
        for (int i = 0; i < 8; i++)
            prev_px[i] = 0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed
        set_geometry(2, 2, 1, 4);
        queue_pixels(4, FILL_ONES);
        drain();
        set_geometry(3, 3, 0, 4);
        queue_pixels(9, FILL_ONES);
        drain();
        pick_idling(3);
        set_geometry(4, 2, 1, 1);
        queue_pixels(8, FILL_ALTERNATE);
        drain();
        reg_write(REG_UNUSED, 16'hffff);
        set_geometry(0, 0, 0, 0);
        queue_pixels(3, FILL_RANDOM);
        drain();
        set_geometry(8191, 5, 1, 7);
        queue_pixels(6, FILL_RANDOM);
        drain();
        set_geometry(3, 65535, 1, 5);
        queue_pixels(15, FILL_RANDOM);
        drain();
        set_geometry(5, 3, 0, 3);
        queue_pixels(15, FILL_ZEROS);
        drain();

        // long line, odd width
        pick_idling(0);
        set_geometry(301, 2, 1, 2);
        queue_pixels(301 * 2, FILL_RANDOM);
        drain();

        // random images, some cut short by a register write
        for (int p = 0; p < 16; p++) begin
            pick_idling(p);
            w = $urandom_range(12, 1);
            h = $urandom_range(10, 1);
            set_geometry(w, h, $urandom_range(1), $urandom_range(7));
            n = w * h * $urandom_range(2, 1);
            if ($urandom_range(5) == 0)
                n = $urandom_range(n, 1);
            if (p == 5) begin
                queue_pixels(n / 2, FILL_RANDOM);
                drain();
                queue_pixels(n - n / 2, FILL_RANDOM);
            end else begin
                queue_pixels(n, FILL_RANDOM);
            end
            drain();
        end

        repeat (200) @(negedge clk);
        if (mismatches == 0 && level_queue.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
